>>> design/polynomial_store_eval_multiply_unit_assert.svh
// Assertion macros for the polynomial store unit.
// No dependencies; expects aclk and aresetn in the including module.
`ifndef POLYNOMIAL_STORE_EVAL_MULTIPLY_UNIT_ASSERT_SVH
`define POLYNOMIAL_STORE_EVAL_MULTIPLY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define PSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSE_ASSERT_ALWAYS(label, cond, msg)
`define PSE_ASSERT_IMPL(label, ante, cons, msg)
`define PSE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/pse_pkg.sv
// Shared types, constants and Q16.16 arithmetic helpers for the polynomial store.
// No dependencies.
package pse_pkg;

    localparam int MAX_TERMS = 64;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int DEG_W     = 6;
    localparam int COEFF_W   = 32;
    localparam int TOP_W     = 7;
    // wide enough for count + degree and for the 7-bit top degree wrap
    localparam int EXT_W     = ((CNT_W > DEG_W) ? CNT_W : DEG_W) + 1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_EVAL   = 2'd1,
        CMD_MUL    = 2'd2,
        CMD_COMMIT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SAT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WR,
        S_EVAL_MUL,
        S_EVAL_ADD,
        S_MUL_RUN,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [COEFF_W-1:0] value;
        logic               sat;
    } q_res_t;

    // floor((p + 2^15) / 2^16), saturated to 32 bits
    function automatic q_res_t q_round_sat(input logic signed [63:0] p);
        logic [64:0] r;
        logic [48:0] s;
        q_res_t      res;
        r = {p[63], p} + 65'd32768;
        s = r[64:16];
        if ((&s[48:31]) || !(|s[48:31])) begin
            res.value = s[31:0];
            res.sat   = 1'b0;
        end else begin
            res.value = s[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

    function automatic q_res_t q_add_sat(input logic [COEFF_W-1:0] a,
                                         input logic [COEFF_W-1:0] b);
        logic [COEFF_W:0] s;
        q_res_t           res;
        s = {a[COEFF_W-1], a} + {b[COEFF_W-1], b};
        if (s[COEFF_W] != s[COEFF_W-1]) begin
            res.value = s[COEFF_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res.sat   = 1'b1;
        end else begin
            res.value = s[COEFF_W-1:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

endpackage

>>> design/pse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pse_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pse_qmul.sv
// Registered 32x32 signed multiplier with Q16.16 rounding and saturation on the output.
// Depends on pse_pkg.
module pse_qmul
    import pse_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COEFF_W-1:0] a,
    input  logic signed [COEFF_W-1:0] b,
    output q_res_t                    res
);

    logic signed [2*COEFF_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    // rounding and clamp sit in the cycle after the multiply
    assign res = q_round_sat(prod_reg);

endmodule

>>> design/polynomial_store_eval_multiply_unit.sv
// Polynomial store with add-term, evaluate, multiply-by-term and commit commands.
// Depends on pse_pkg, pse_ram, pse_qmul and the assertion macro header.
//
// Usage:
//   One transaction on the s_ channel carries a command; exactly one result
//   transaction follows on the m_ channel, in order. Both channels are
//   valid/ready. Coefficients and results are signed Q16.16.
//
// Command steps:
//   add term   read, modify-write, result
//   evaluate   Horner loop: multiply, then round/add per term,
//              the accumulator feedback through the multiplier
//   multiply   one coefficient per cycle through a 3-stage
//              read / multiply / accumulate-write pipeline
//   commit     bank swap, no data copy
//   A new transaction is taken only in idle; the result sits in an output
//   register, so the next command is accepted while the result waits.
//   If the receiver stalls, the block finishes the next command and then
//   holds it until the output register frees up.
//
// Reset: each bank keeps a written flag per entry; an entry with its flag
// clear reads as zero. Reset clears all flags and commit clears the flags of
// the bank that becomes the product store, so no clearing pass is needed.
`include "polynomial_store_eval_multiply_unit_assert.svh"

module polynomial_store_eval_multiply_unit
    import pse_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic [DEG_W-1:0]          s_term_degree,
    input  logic signed [COEFF_W-1:0] s_term_coeff,
    input  logic signed [COEFF_W-1:0] s_point_x,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COEFF_W-1:0] m_value,
    output logic signed [TOP_W-1:0]   m_top_degree,
    output logic [1:0]                m_status
);

    // ---------------- control state ----------------
    fsm_t             state_reg, state_next;
    logic             sel_reg, sel_next;          // 0: bank0 holds the polynomial
    logic [CNT_W-1:0] coeff_count_reg, coeff_count_next;
    logic [CNT_W-1:0] product_count_reg, product_count_next;
    logic             m_valid_reg, m_valid_next;
    logic             v1_reg, v1_next;            // multiply pipe: data stage
    logic             v2_reg, v2_next;            // multiply pipe: write stage

    // ---------------- per-transaction payload ----------------
    cmd_t               cmd_reg, cmd_next;
    logic [DEG_W-1:0]   deg_reg, deg_next;
    logic [COEFF_W-1:0] c_reg, c_next;
    logic [COEFF_W-1:0] x_reg, x_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [COEFF_W-1:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic               range_reg, range_next;
    logic               pm1_reg, pm1_next;        // product entry below count
    logic [ADDR_W-1:0]  waddr1_reg, waddr1_next;
    logic [ADDR_W-1:0]  waddr2_reg, waddr2_next;
    logic [COEFF_W-1:0] pdata2_reg, pdata2_next;
    logic [COEFF_W-1:0] m_value_reg, m_value_next;
    logic [TOP_W-1:0]   m_top_reg, m_top_next;
    status_t            m_status_reg, m_status_next;

    // ---------------- memory ports (logical view) ----------------
    logic [ADDR_W-1:0]  c_raddr, p_raddr, c_waddr, p_waddr;
    logic               c_we, p_we;
    logic [COEFF_W-1:0] c_wdata, p_wdata, c_rdata, p_rdata;

    logic               b0_we, b1_we;
    logic [ADDR_W-1:0]  b0_waddr, b1_waddr, b0_raddr, b1_raddr;
    logic [COEFF_W-1:0] b0_wdata, b1_wdata, b0_rdata, b1_rdata;
    logic [COEFF_W-1:0] b0_ram_rdata, b1_ram_rdata;

    // written flags per bank; hit flags follow the registered read
    logic                 bank_clr;
    logic [MAX_TERMS-1:0] b0_vld_reg, b0_vld_next;
    logic [MAX_TERMS-1:0] b1_vld_reg, b1_vld_next;
    logic                 b0_hit_reg, b1_hit_reg;

    // ---------------- multiplier ----------------
    logic               mul_en;
    logic [COEFF_W-1:0] mul_a, mul_b;
    q_res_t             mul_res;

    // unwritten entries read as zero
    assign b0_rdata = b0_hit_reg ? b0_ram_rdata : '0;
    assign b1_rdata = b1_hit_reg ? b1_ram_rdata : '0;

    // Bank steering: commit just flips which bank is the polynomial.
    always_comb begin
        b0_we    = sel_reg ? p_we    : c_we;
        b0_waddr = sel_reg ? p_waddr : c_waddr;
        b0_wdata = sel_reg ? p_wdata : c_wdata;
        b0_raddr = sel_reg ? p_raddr : c_raddr;
        b1_we    = sel_reg ? c_we    : p_we;
        b1_waddr = sel_reg ? c_waddr : p_waddr;
        b1_wdata = sel_reg ? c_wdata : p_wdata;
        b1_raddr = sel_reg ? c_raddr : p_raddr;
        c_rdata  = sel_reg ? b1_rdata : b0_rdata;
        p_rdata  = sel_reg ? b0_rdata : b1_rdata;
    end

    // Written flags: set on write, cleared for the bank that becomes the product.
    always_comb begin
        b0_vld_next = b0_vld_reg;
        b1_vld_next = b1_vld_reg;
        if (b0_we) begin
            b0_vld_next[b0_waddr] = 1'b1;
        end
        if (b1_we) begin
            b1_vld_next[b1_waddr] = 1'b1;
        end
        if (bank_clr) begin
            if (sel_reg) begin
                b1_vld_next = '0;
            end else begin
                b0_vld_next = '0;
            end
        end
    end

    pse_ram #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_W)
    ) u_bank0 (
        .aclk  (aclk),
        .we    (b0_we),
        .waddr (b0_waddr),
        .wdata (b0_wdata),
        .raddr (b0_raddr),
        .rdata (b0_ram_rdata)
    );

    pse_ram #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_W)
    ) u_bank1 (
        .aclk  (aclk),
        .we    (b1_we),
        .waddr (b1_waddr),
        .wdata (b1_wdata),
        .raddr (b1_raddr),
        .rdata (b1_ram_rdata)
    );

    pse_qmul u_qmul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .res  (mul_res)
    );

    // ---------------- next state and datapath control ----------------
    always_comb begin
        q_res_t           add_r;
        logic [EXT_W-1:0] paddr_ext;
        logic [EXT_W-1:0] mul_top;
        logic             issue;

        state_next         = state_reg;
        sel_next           = sel_reg;
        coeff_count_next   = coeff_count_reg;
        product_count_next = product_count_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        v1_next            = 1'b0;
        v2_next            = 1'b0;
        cmd_next           = cmd_reg;
        deg_next           = deg_reg;
        c_next             = c_reg;
        x_next             = x_reg;
        idx_next           = idx_reg;
        acc_next           = acc_reg;
        sat_next           = sat_reg;
        range_next         = range_reg;
        pm1_next           = pm1_reg;
        waddr1_next        = waddr1_reg;
        waddr2_next        = waddr2_reg;
        pdata2_next        = pdata2_reg;
        m_value_next       = m_value_reg;
        m_top_next         = m_top_reg;
        m_status_next      = m_status_reg;

        c_raddr  = ADDR_W'(deg_reg);
        p_raddr  = '0;
        c_we     = 1'b0;
        c_waddr  = ADDR_W'(deg_reg);
        c_wdata  = '0;
        p_we     = 1'b0;
        p_waddr  = waddr2_reg;
        p_wdata  = '0;
        mul_en   = 1'b0;
        mul_a    = acc_reg;
        mul_b    = x_reg;
        bank_clr = 1'b0;

        add_r     = '0;
        issue     = 1'b0;
        paddr_ext = EXT_W'(idx_reg) + EXT_W'(deg_reg);
        mul_top   = EXT_W'(coeff_count_reg) + EXT_W'(s_term_degree) - EXT_W'(1);

        s_ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                // add reads its target entry in the accept cycle
                c_raddr = ADDR_W'(s_term_degree);
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_command);
                    deg_next   = s_term_degree;
                    c_next     = s_term_coeff;
                    x_next     = s_point_x;
                    acc_next   = '0;
                    sat_next   = 1'b0;
                    range_next = 1'b0;
                    idx_next   = '0;
                    unique case (cmd_t'(s_command))
                        CMD_ADD: begin
                            if (EXT_W'(s_term_degree) >= EXT_W'(MAX_TERMS)) begin
                                range_next = 1'b1;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_ADD_WR;
                            end
                        end
                        CMD_EVAL: begin
                            if (coeff_count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                idx_next   = coeff_count_reg - CNT_W'(1);
                                state_next = S_EVAL_MUL;
                            end
                        end
                        CMD_MUL: begin
                            if (coeff_count_reg == '0) begin
                                state_next = S_DONE;
                            end else if (mul_top >= EXT_W'(MAX_TERMS)) begin
                                range_next = 1'b1;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_MUL_RUN;
                            end
                        end
                        CMD_COMMIT: begin
                            sel_next           = !sel_reg;
                            bank_clr           = 1'b1;
                            coeff_count_next   = product_count_reg;
                            product_count_next = '0;
                            state_next         = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_ADD_WR: begin
                // entries at or above the count are zero by construction
                if (EXT_W'(deg_reg) < EXT_W'(coeff_count_reg)) begin
                    add_r = q_add_sat(c_rdata, c_reg);
                end else begin
                    add_r = q_add_sat('0, c_reg);
                end
                c_we     = 1'b1;
                c_wdata  = add_r.value;
                sat_next = add_r.sat;
                if (EXT_W'(deg_reg) + EXT_W'(1) > EXT_W'(coeff_count_reg)) begin
                    coeff_count_next = CNT_W'(EXT_W'(deg_reg) + EXT_W'(1));
                end
                state_next = S_DONE;
            end

            S_EVAL_MUL: begin
                c_raddr    = ADDR_W'(idx_reg);
                mul_en     = 1'b1;
                state_next = S_EVAL_ADD;
            end

            S_EVAL_ADD: begin
                add_r    = q_add_sat(mul_res.value, c_rdata);
                acc_next = add_r.value;
                sat_next = sat_reg || mul_res.sat || add_r.sat;
                if (idx_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_EVAL_MUL;
                end
            end

            S_MUL_RUN: begin
                // stage 0: read coefficient i and product entry i + degree
                issue = (idx_reg < coeff_count_reg);
                if (issue) begin
                    c_raddr     = ADDR_W'(idx_reg);
                    p_raddr     = ADDR_W'(paddr_ext);
                    v1_next     = 1'b1;
                    waddr1_next = ADDR_W'(paddr_ext);
                    pm1_next    = (paddr_ext < EXT_W'(product_count_reg));
                    idx_next    = idx_reg + CNT_W'(1);
                end
                // stage 1: multiply, hold product entry
                if (v1_reg) begin
                    mul_en      = 1'b1;
                    mul_a       = c_rdata;
                    mul_b       = c_reg;
                    v2_next     = 1'b1;
                    waddr2_next = waddr1_reg;
                    pdata2_next = pm1_reg ? p_rdata : '0;
                end
                // stage 2: round, accumulate, write back
                if (v2_reg) begin
                    add_r    = q_add_sat(pdata2_reg, mul_res.value);
                    p_we     = 1'b1;
                    p_wdata  = add_r.value;
                    sat_next = sat_reg || mul_res.sat || add_r.sat;
                end
                if (!issue && !v1_reg && !v2_reg) begin
                    if (EXT_W'(coeff_count_reg) + EXT_W'(deg_reg) >
                        EXT_W'(product_count_reg)) begin
                        product_count_next =
                            CNT_W'(EXT_W'(coeff_count_reg) + EXT_W'(deg_reg));
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = (cmd_reg == CMD_EVAL) ? acc_reg : '0;
                    m_top_next   = TOP_W'(EXT_W'(coeff_count_reg) - EXT_W'(1));
                    if (range_reg) begin
                        m_status_next = STAT_RANGE;
                    end else if (sat_reg) begin
                        m_status_next = STAT_SAT;
                    end else begin
                        m_status_next = STAT_OK;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            sel_reg           <= 1'b0;
            coeff_count_reg   <= '0;
            product_count_reg <= '0;
            m_valid_reg       <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            b0_vld_reg        <= '0;
            b1_vld_reg        <= '0;
            b0_hit_reg        <= 1'b0;
            b1_hit_reg        <= 1'b0;
        end else begin
            state_reg         <= state_next;
            sel_reg           <= sel_next;
            coeff_count_reg   <= coeff_count_next;
            product_count_reg <= product_count_next;
            m_valid_reg       <= m_valid_next;
            v1_reg            <= v1_next;
            v2_reg            <= v2_next;
            b0_vld_reg        <= b0_vld_next;
            b1_vld_reg        <= b1_vld_next;
            b0_hit_reg        <= b0_vld_reg[b0_raddr];
            b1_hit_reg        <= b1_vld_reg[b1_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        deg_reg      <= deg_next;
        c_reg        <= c_next;
        x_reg        <= x_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        sat_reg      <= sat_next;
        range_reg    <= range_next;
        pm1_reg      <= pm1_next;
        waddr1_reg   <= waddr1_next;
        waddr2_reg   <= waddr2_next;
        pdata2_reg   <= pdata2_next;
        m_value_reg  <= m_value_next;
        m_top_reg    <= m_top_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_top_degree = m_top_reg;
    assign m_status     = m_status_reg;

    // ---------------- assertions ----------------
    `PSE_ASSERT_ALWAYS(a_counts_bounded, (EXT_W'(coeff_count_reg) <= EXT_W'(MAX_TERMS)) && (EXT_W'(product_count_reg) <= EXT_W'(MAX_TERMS)), "term count above capacity")
    `PSE_ASSERT_NEXT(a_commit_clears, s_valid && s_ready && (s_command == CMD_COMMIT), product_count_reg == '0, "product store not emptied by commit")
    `PSE_ASSERT_IMPL(a_pipe_empty_idle, s_ready, !v1_reg && !v2_reg, "multiply pipe busy while idle")

endmodule
